### rtl/bakery_ticket_lock_arbiter_defines.svh
// Assertion macros shared by the checker of the bakery ticket lock arbiter.
`ifndef BAKERY_TICKET_LOCK_ARBITER_DEFINES_SVH
`define BAKERY_TICKET_LOCK_ARBITER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BKL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BKL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bkl_pkg.sv
`default_nettype none

package bkl_pkg;

    // Sequencer states of the arbiter
    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    // Control handed from the sequencer to every cell
    typedef struct packed {
        logic wr_en;   // write the selected cell's ticket this cycle
        logic excl;    // leave the selected cell out of the holder search
    } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/bkl_cell.sv
`default_nettype none

module bkl_cell #(
    parameter int INDEX       = 0,
    parameter int TICKET_BITS = 16,
    parameter int IDW         = 4,
    parameter int CNT_W       = 5
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bkl_pkg::cell_ctl_t     ctl,
    input  wire logic [CNT_W-1:0]       count,
    input  wire logic [IDW-1:0]         sel_thread,
    input  wire logic [TICKET_BITS-1:0] wr_value,
    input  wire logic                   tok_in,
    input  wire logic [TICKET_BITS-1:0] max_in,
    input  wire logic                   hv_in,
    input  wire logic [IDW-1:0]         hid_in,
    input  wire logic [TICKET_BITS-1:0] htk_in,
    output logic                        tok_out,
    output logic [TICKET_BITS-1:0]      max_out,
    output logic                        hv_out,
    output logic [IDW-1:0]              hid_out,
    output logic [TICKET_BITS-1:0]      htk_out
);
    import bkl_pkg::*;

    localparam logic [IDW-1:0]   MY_ID  = IDW'(INDEX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

    logic [TICKET_BITS-1:0] ticket_reg;
    logic [TICKET_BITS-1:0] ticket_next;
    logic                   tok_reg;
    logic [TICKET_BITS-1:0] max_reg;
    logic [TICKET_BITS-1:0] max_next;
    logic                   hv_reg;
    logic                   hv_next;
    logic [IDW-1:0]         hid_reg;
    logic [IDW-1:0]         hid_next;
    logic [TICKET_BITS-1:0] htk_reg;
    logic [TICKET_BITS-1:0] htk_next;
    logic                   part;
    logic                   cand;
    logic                   selected;

    // Decide whether this entry takes part in the sweep
    always_comb
    begin
        selected = (sel_thread == MY_ID);
        part     = (MY_POS < count);
        cand     = part && !(ctl.excl && selected) && (ticket_reg != '0);
    end

    // Fold this entry into the running maximum and holder
    always_comb
    begin
        max_next = max_in;
        if (part && (ticket_reg > max_in))
        begin
            max_next = ticket_reg;
        end
        hv_next  = hv_in;
        hid_next = hid_in;
        htk_next = htk_in;
        if (cand && (!hv_in || (ticket_reg < htk_in)))
        begin
            hv_next  = 1'b1;
            hid_next = MY_ID;
            htk_next = ticket_reg;
        end
    end

    // Take a new ticket when the sequencer writes this entry
    always_comb
    begin
        ticket_next = ticket_reg;
        if (ctl.wr_en && selected)
        begin
            ticket_next = wr_value;
        end
    end

    // Hold the ticket and the token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticket_reg <= '0;
            tok_reg    <= 1'b0;
        end
        else
        begin
            ticket_reg <= ticket_next;
            tok_reg    <= tok_in;
        end
    end

    // Advance the partial results to the next cell
    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        hv_reg  <= hv_next;
        hid_reg <= hid_next;
        htk_reg <= htk_next;
    end

    assign tok_out = tok_reg;
    assign max_out = max_reg;
    assign hv_out  = hv_reg;
    assign hid_out = hid_reg;
    assign htk_out = htk_reg;

endmodule

`default_nettype wire

### rtl/bakery_ticket_lock_arbiter.sv
// Bakery ticket lock arbiter. Pulse start with op (0 request, 1 release) and
// thread while busy is low; one result comes back on a one-cycle done strobe,
// and the receiver cannot stall it, so capture it in that cycle. After each
// accept a token walks the row of ticket cells one cell per cycle,
// gathering the largest ticket and the current holder, and the ticket
// is written and the result registered in the cycle the token leaves the last
// cell; busy stays high until then. The active thread count may be written
// through cfg_we and cfg_wdata whenever no item is in flight; values above
// MAX_THREADS act as MAX_THREADS.
`default_nettype none

module bakery_ticket_lock_arbiter #(
    parameter int MAX_THREADS = 16,
    parameter int TICKET_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [$clog2(MAX_THREADS+1)-1:0]      cfg_wdata,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  op,
    input  wire logic [$clog2(MAX_THREADS)-1:0]        thread,
    output logic                                       done,
    output logic [TICKET_BITS-1:0]                     assigned_ticket,
    output logic                                       holder_valid,
    output logic [$clog2(MAX_THREADS)-1:0]             holder_id,
    output logic [TICKET_BITS-1:0]                     holder_ticket,
    output logic [1:0]                                 status
);
    import bkl_pkg::*;

    localparam int IDW   = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam logic [CNT_W-1:0]       CNT_MAX    = CNT_W'(MAX_THREADS);
    localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       active_reg;
    logic [CNT_W-1:0]       eff_count;
    logic                   accept;
    logic                   finish;
    logic                   tok_launch_reg;
    logic                   op_reg;
    logic [IDW-1:0]         thread_reg;
    logic                   in_range_reg;
    logic                   in_range;
    cell_ctl_t              ctl;

    logic [TICKET_BITS-1:0] assigned;
    logic                   sat;
    logic                   new_wins;
    logic                   do_req;
    logic [TICKET_BITS-1:0] res_assigned;
    logic                   res_hv;
    logic [IDW-1:0]         res_hid;
    logic [TICKET_BITS-1:0] res_htk;
    logic [1:0]             res_status;

    logic                   done_reg;
    logic [TICKET_BITS-1:0] assigned_reg;
    logic                   hv_reg;
    logic [IDW-1:0]         hid_reg;
    logic [TICKET_BITS-1:0] htk_reg;
    logic [1:0]             status_reg;

    // Chain taps between cells
    logic                   ch_tok [0:MAX_THREADS];
    logic [TICKET_BITS-1:0] ch_max [0:MAX_THREADS];
    logic                   ch_hv  [0:MAX_THREADS];
    logic [IDW-1:0]         ch_hid [0:MAX_THREADS];
    logic [TICKET_BITS-1:0] ch_htk [0:MAX_THREADS];

    // Cap the thread count
    assign eff_count = (active_reg > CNT_MAX) ? CNT_MAX : active_reg;
    assign in_range  = (CNT_W'(thread) < eff_count);

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= CNT_MAX;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_wdata;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (ch_tok[MAX_THREADS])
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        busy   = 1'b1;
        accept = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy   = 1'b0;
                accept = start;
            end
            ST_SWEEP:
            begin
                finish = ch_tok[MAX_THREADS];
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tok_launch_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tok_launch_reg <= accept;
            done_reg       <= finish;
        end
    end

    // Latch the item on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op;
            thread_reg   <= thread;
            in_range_reg <= in_range;
        end
    end

    // Feed the head of the chain
    assign ch_tok[0] = tok_launch_reg;
    assign ch_max[0] = '0;
    assign ch_hv[0]  = 1'b0;
    assign ch_hid[0] = '0;
    assign ch_htk[0] = '0;

    // Drive the cell controls
    always_comb
    begin
        ctl.wr_en = finish && in_range_reg;
        ctl.excl  = in_range_reg;
    end

    // Row of ticket cells
    for (genvar i = 0; i < MAX_THREADS; i++)
    begin : g_cell
        bkl_cell #(
            .INDEX       (i),
            .TICKET_BITS (TICKET_BITS),
            .IDW         (IDW),
            .CNT_W       (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .count      (eff_count),
            .sel_thread (thread_reg),
            .wr_value   (res_assigned),
            .tok_in     (ch_tok[i]),
            .max_in     (ch_max[i]),
            .hv_in      (ch_hv[i]),
            .hid_in     (ch_hid[i]),
            .htk_in     (ch_htk[i]),
            .tok_out    (ch_tok[i+1]),
            .max_out    (ch_max[i+1]),
            .hv_out     (ch_hv[i+1]),
            .hid_out    (ch_hid[i+1]),
            .htk_out    (ch_htk[i+1])
        );
    end

    // Form the ticket and the new holder from the sweep
    always_comb
    begin
        sat      = (ch_max[MAX_THREADS] == TICKET_TOP);
        assigned = sat ? TICKET_TOP : (ch_max[MAX_THREADS] + 1'b1);
        do_req   = in_range_reg && !op_reg;
        new_wins = !ch_hv[MAX_THREADS]
                   || (assigned < ch_htk[MAX_THREADS])
                   || ((assigned == ch_htk[MAX_THREADS])
                       && (thread_reg < ch_hid[MAX_THREADS]));

        res_assigned = do_req ? assigned : '0;
        res_hv       = ch_hv[MAX_THREADS];
        res_hid      = ch_hid[MAX_THREADS];
        res_htk      = ch_htk[MAX_THREADS];
        if (do_req && new_wins)
        begin
            res_hv  = 1'b1;
            res_hid = thread_reg;
            res_htk = assigned;
        end

        if (!in_range_reg)
        begin
            res_status = STATUS_RANGE;
        end
        else if (do_req && sat)
        begin
            res_status = STATUS_SAT;
        end
        else
        begin
            res_status = STATUS_OK;
        end
    end

    // Register the result
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            assigned_reg <= res_assigned;
            hv_reg       <= res_hv;
            hid_reg      <= res_hid;
            htk_reg      <= res_htk;
            status_reg   <= res_status;
        end
    end

    assign done            = done_reg;
    assign assigned_ticket = assigned_reg;
    assign holder_valid    = hv_reg;
    assign holder_id       = hid_reg;
    assign holder_ticket   = htk_reg;
    assign status          = status_reg;

endmodule

`default_nettype wire

### rtl/bkl_checker.sv
`default_nettype none

`include "bakery_ticket_lock_arbiter_defines.svh"

module bkl_checker #(
    parameter int MAX_THREADS = 16,
    parameter int TICKET_BITS = 16
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic [TICKET_BITS-1:0]            assigned_ticket,
    input wire logic                              holder_valid,
    input wire logic [$clog2(MAX_THREADS)-1:0]    holder_id,
    input wire logic [TICKET_BITS-1:0]            holder_ticket,
    input wire logic [1:0]                        status
);
    import bkl_pkg::*;

    localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

    // A transfer keeps the block busy until its result
    `BKL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after transfer")

    // The result strobe comes with the block free again
    `BKL_ASSERT_SAME(a_done_free, done, !busy, "result shown while busy")

    // A rejected thread id gets no ticket
    `BKL_ASSERT_SAME(a_range_zero, done && (status == STATUS_RANGE),
        assigned_ticket == '0, "ticket given to out-of-range thread")

    // A saturated request gets the top ticket and becomes a candidate holder
    `BKL_ASSERT_SAME(a_sat_top, done && (status == STATUS_SAT),
        (assigned_ticket == TICKET_TOP) && holder_valid, "bad saturated result")

    // No holder reads as zero
    `BKL_ASSERT_SAME(a_no_holder, done && !holder_valid,
        (holder_id == '0) && (holder_ticket == '0), "stale holder fields")

endmodule

bind bakery_ticket_lock_arbiter bkl_checker #(
    .MAX_THREADS (MAX_THREADS),
    .TICKET_BITS (TICKET_BITS)
) u_bkl_checker (.*);

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
    import bkl_pkg::*;

    localparam int MAX_THREADS = 16;
    localparam int TICKET_BITS = 16;
    localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;
    localparam int CYCLE_LIMIT = 200_000;

    typedef enum logic [1:0] {
        ACT_TRANSFER,
        ACT_SET_COUNT,
        ACT_DRAIN
    } lock_action_t;

    typedef struct {
        lock_action_t action;
        logic         op;
        logic [3:0]   tid;
        logic [4:0]   count;
        int           gap;
    } lock_op_t;

    typedef struct packed {
        logic [TICKET_BITS-1:0] ticket;
        logic                   valid;
        logic [3:0]             owner;
        logic [TICKET_BITS-1:0] owner_ticket;
        logic [1:0]             status;
    } owner_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic start = 1'b0;
    logic op = OP_REQUEST;
    logic [3:0] thread = '0;
    logic busy;
    logic done;
    logic [TICKET_BITS-1:0] assigned_ticket;
    logic holder_valid;
    logic [3:0] holder_id;
    logic [TICKET_BITS-1:0] holder_ticket;
    logic [1:0] status;

    // Shadow of the lock state
    logic [TICKET_BITS-1:0] ticket_copy [MAX_THREADS];
    logic [4:0] thread_limit = 5'd16;

    lock_op_t lock_ops[$];
    owner_report_t owner_forecast[$];
    lock_op_t cur_op;
    bit holding = 1'b0;
    int gap_left = 0;
    bit took_transfer = 1'b0;
    int mismatches = 0;
    int reports_seen = 0;
    int cycle_count = 0;

    bakery_ticket_lock_arbiter #(
        .MAX_THREADS(MAX_THREADS),
        .TICKET_BITS(TICKET_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .start(start),
        .busy(busy),
        .op(op),
        .thread(thread),
        .done(done),
        .assigned_ticket(assigned_ticket),
        .holder_valid(holder_valid),
        .holder_id(holder_id),
        .holder_ticket(holder_ticket),
        .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            ticket_copy[i] = '0;
        end
    end

    // Apply one request or release to the shadow table and work out the owner
    function automatic owner_report_t apply_lock_op(logic rel, logic [3:0] tid);
        owner_report_t r;
        int n;
        logic [TICKET_BITS-1:0] top;
        n = (thread_limit > MAX_THREADS) ? MAX_THREADS : int'(thread_limit);
        r = '0;
        r.status = STATUS_OK;
        if (tid >= n)
        begin
            r.status = STATUS_RANGE;
        end
        else if (rel == OP_REQUEST)
        begin
            top = '0;
            for (int i = 0; i < n; i++)
            begin
                if (ticket_copy[i] > top)
                    top = ticket_copy[i];
            end
            if (top >= TICKET_TOP)
            begin
                r.ticket = TICKET_TOP;
                r.status = STATUS_SAT;
            end
            else
            begin
                r.ticket = top + 1'b1;
            end
            ticket_copy[tid] = r.ticket;
        end
        else
        begin
            ticket_copy[tid] = '0;
        end
        // lowest (ticket, id) among the active entries owns the lock
        for (int i = 0; i < n; i++)
        begin
            if (ticket_copy[i] != '0 && (!r.valid || ticket_copy[i] < r.owner_ticket))
            begin
                r.valid = 1'b1;
                r.owner = i[3:0];
                r.owner_ticket = ticket_copy[i];
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch on result %0d, %s: got %0d, want %0d",
                 reports_seen, what, got, want);
    endtask

    task automatic queue_op(input logic rel, input logic [3:0] tid, input int gap);
        lock_op_t e;
        e.action = ACT_TRANSFER;
        e.op = rel;
        e.tid = tid;
        e.count = '0;
        e.gap = gap;
        lock_ops.push_back(e);
    endtask

    task automatic queue_count(input logic [4:0] count);
        lock_op_t e;
        e.action = ACT_SET_COUNT;
        e.op = OP_REQUEST;
        e.tid = '0;
        e.count = count;
        e.gap = 0;
        lock_ops.push_back(e);
    endtask

    task automatic queue_drain();
        lock_op_t e;
        e.action = ACT_DRAIN;
        e.op = OP_REQUEST;
        e.tid = '0;
        e.count = '0;
        e.gap = 0;
        lock_ops.push_back(e);
    endtask

    // Driver: present the next operation at the falling edge
    always @(negedge clk)
    begin
        logic nxt_start;
        logic nxt_we;
        nxt_start = start;
        nxt_we = 1'b0;
        if (rst_n)
        begin
            if (start && took_transfer)
                nxt_start = 1'b0;
            if (!nxt_start)
            begin
                if (!holding && lock_ops.size() != 0)
                begin
                    cur_op = lock_ops.pop_front();
                    holding = 1'b1;
                    gap_left = cur_op.gap;
                end
                if (holding)
                begin
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    else
                    begin
                        case (cur_op.action)
                            ACT_TRANSFER:
                            begin
                                nxt_start = 1'b1;
                                op <= cur_op.op;
                                thread <= cur_op.tid;
                                holding = 1'b0;
                            end
                            ACT_SET_COUNT:
                            begin
                                // write only once the arbiter has gone quiet
                                if (owner_forecast.size() == 0 && !busy)
                                begin
                                    nxt_we = 1'b1;
                                    cfg_wdata <= cur_op.count;
                                    holding = 1'b0;
                                end
                            end
                            default:
                            begin
                                if (owner_forecast.size() == 0)
                                    holding = 1'b0;
                            end
                        endcase
                    end
                end
            end
        end
        start <= nxt_start;
        cfg_we <= nxt_we;
    end

    // Monitor: check the owner report, then predict for a new transfer
    always @(posedge clk)
    begin
        owner_report_t want;
        if (!rst_n)
        begin
            took_transfer <= 1'b0;
        end
        else
        begin
            took_transfer <= start && !busy;
            if (cfg_we)
                thread_limit = cfg_wdata;
            if (done)
            begin
                if (owner_forecast.size() == 0)
                begin
                    flag_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    want = owner_forecast.pop_front();
                    if (assigned_ticket !== want.ticket)
                        flag_mismatch("assigned_ticket", assigned_ticket, want.ticket);
                    if (holder_valid !== want.valid)
                        flag_mismatch("holder_valid", holder_valid, want.valid);
                    if (holder_id !== want.owner)
                        flag_mismatch("holder_id", holder_id, want.owner);
                    if (holder_ticket !== want.owner_ticket)
                        flag_mismatch("holder_ticket", holder_ticket, want.owner_ticket);
                    if (status !== want.status)
                        flag_mismatch("status", status, want.status);
                end
                reports_seen++;
            end
            if (start && !busy)
                owner_forecast.push_back(apply_lock_op(op, thread));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        logic [4:0] lim;
        int eff;
        int gap;
        logic rel;
        logic [3:0] tid;

        // Tie between a hidden entry and a fresh one, then range and repeats
        queue_op(OP_REQUEST, 4'd8, $urandom_range(0, 9));
        queue_count(5'd2);
        queue_op(OP_REQUEST, 4'd0, $urandom_range(0, 9));
        queue_op(OP_REQUEST, 4'd1, $urandom_range(0, 9));
        queue_op(OP_REQUEST, 4'd5, $urandom_range(0, 9));
        queue_op(OP_RELEASE, 4'd15, $urandom_range(0, 9));
        queue_count(5'd16);
        queue_op(OP_RELEASE, 4'd0, $urandom_range(0, 9));
        queue_op(OP_REQUEST, 4'd15, $urandom_range(0, 9));
        queue_op(OP_REQUEST, 4'd15, $urandom_range(0, 9));
        queue_op(OP_RELEASE, 4'd3, $urandom_range(0, 9));
        queue_op(OP_RELEASE, 4'd8, $urandom_range(0, 9));
        queue_count(5'd0);
        queue_op(OP_REQUEST, 4'd0, $urandom_range(0, 9));
        queue_op(OP_RELEASE, 4'd0, $urandom_range(0, 9));
        queue_count(5'd31);
        queue_op(OP_REQUEST, 4'd15, $urandom_range(0, 9));
        queue_op(OP_RELEASE, 4'd1, $urandom_range(0, 9));
        queue_op(OP_RELEASE, 4'd15, $urandom_range(0, 9));
        queue_count(5'd1);
        queue_op(OP_REQUEST, 4'd0, $urandom_range(0, 9));
        queue_op(OP_REQUEST, 4'd1, $urandom_range(0, 9));
        queue_op(OP_RELEASE, 4'd0, $urandom_range(0, 9));
        queue_count(5'd17);
        queue_op(OP_REQUEST, 4'd10, $urandom_range(0, 9));
        queue_drain();

        // Random phases over several thread counts; one phase runs back to back
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: lim = 5'd16;
                1: lim = 5'd3;
                2: lim = 5'd16;
                3: lim = 5'd1;
                4: lim = 5'($urandom_range(0, 31));
                default: lim = 5'd8;
            endcase
            queue_count(lim);
            eff = (lim > MAX_THREADS) ? MAX_THREADS : int'(lim);
            for (int k = 0; k < 100; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                    queue_drain();
                rel = ($urandom_range(0, 9) < 6) ? OP_REQUEST : OP_RELEASE;
                if (eff == 0 || $urandom_range(0, 9) == 0)
                    tid = 4'($urandom_range(0, 15));
                else
                    tid = 4'($urandom_range(0, eff - 1));
                gap = (ph == 2) ? 0 : $urandom_range(0, 9);
                queue_op(rel, tid, gap);
            end
        end

        // Repeat requests and releases over the full table
        queue_count(5'd16);
        queue_op(OP_REQUEST, 4'd5, $urandom_range(0, 9));
        queue_op(OP_REQUEST, 4'd5, $urandom_range(0, 9));
        queue_op(OP_RELEASE, 4'd0, $urandom_range(0, 9));
        queue_op(OP_REQUEST, 4'd9, $urandom_range(0, 9));
        // clear the table and start over from the bottom
        for (int i = 0; i < MAX_THREADS; i++)
            queue_op(OP_RELEASE, 4'(i), $urandom_range(0, 9));
        queue_op(OP_REQUEST, 4'd2, $urandom_range(0, 9));
        queue_op(OP_REQUEST, 4'd14, $urandom_range(0, 9));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Let the last transfers drain, then allow for the arbiter's latency
        while (lock_ops.size() != 0 || holding || start || owner_forecast.size() != 0)
            @(posedge clk);
        repeat (MAX_THREADS + 6) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
